// ===== sv/ip_prefix_predecessor_table_macros.svh =====
// assertion helpers for the top-level rtl file
`ifndef IP_PREFIX_PREDECESSOR_TABLE_MACROS_SVH
`define IP_PREFIX_PREDECESSOR_TABLE_MACROS_SVH

// same-cycle implication, off during reset
`define IPPT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, off during reset
`define IPPT_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ippt_pkg.sv =====
`timescale 1ns / 1ps
package ippt_pkg;

	localparam int V4_ENTRIES  = 64;
	localparam int V6_ENTRIES  = 64;
	localparam int HANDLE_BITS = 16;

	localparam int TOTAL_CELLS = V4_ENTRIES + V6_ENTRIES;
	localparam int KEY_W       = 64;
	localparam int V4_KEY_W    = 32;
	localparam int MASK_W      = 8;
	localparam int FILL4_W     = $clog2(V4_ENTRIES + 1);
	localparam int FILL6_W     = $clog2(V6_ENTRIES + 1);
	localparam int COUNT_W     = 7;
	localparam int OUT_HANDLE_W = 16;

	localparam logic [MASK_W-1:0] V4_MASK_LO = 8'd8;
	localparam logic [MASK_W-1:0] V4_MASK_HI = 8'd32;
	localparam logic [MASK_W-1:0] V6_MASK_LO = 8'd16;
	localparam logic [MASK_W-1:0] V6_MASK_HI = 8'd64;

	typedef enum logic [1:0] {
		REQ_INSERT = 2'd0,
		REQ_DELETE = 2'd1,
		REQ_FIND   = 2'd2,
		REQ_CLEAR  = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		ST_OK   = 3'd0,
		ST_ZERO = 3'd1,
		ST_MASK = 3'd2,
		ST_DUP  = 3'd3,
		ST_FULL = 3'd4,
		ST_MISS = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD  = 2'd0,
		OP_NEW   = 2'd1,
		OP_LEFT  = 2'd2,
		OP_RIGHT = 2'd3
	} cell_op_t;

	typedef struct packed {
		logic [KEY_W-1:0]       key;
		logic [MASK_W-1:0]      mask;
		logic [HANDLE_BITS-1:0] handle;
	} entry_t;

	typedef struct packed {
		logic le;
		logic eq;
	} cell_flags_t;

endpackage

// ===== sv/ippt_cell.sv =====
`timescale 1ns / 1ps
module ippt_cell import ippt_pkg::*; (
	input  logic             clk,
	input  cell_op_t         op,
	input  entry_t           new_entry,
	input  entry_t           left_entry,
	input  entry_t           right_entry,
	input  logic [KEY_W-1:0] cmp_key,
	input  logic             valid,
	output entry_t           entry,
	output cell_flags_t      flags
);

	entry_t entry_q;

	always_ff @(posedge clk) begin
		unique case (op)
			OP_HOLD:  entry_q <= entry_q;
			OP_NEW:   entry_q <= new_entry;
			OP_LEFT:  entry_q <= left_entry;
			OP_RIGHT: entry_q <= right_entry;
		endcase
	end

	assign entry    = entry_q;
	assign flags.le = valid && (entry_q.key <= cmp_key);
	assign flags.eq = valid && (entry_q.key == cmp_key);

endmodule

// ===== sv/ippt_match.sv =====
`timescale 1ns / 1ps
module ippt_match import ippt_pkg::*; (
	input  entry_t           cand,
	input  logic [KEY_W-1:0] addr,
	input  logic             v6,
	output logic             hit
);

	logic [MASK_W-1:0] lo;
	logic [MASK_W-1:0] hi;
	logic [MASK_W-1:0] shamt;
	logic [KEY_W-1:0]  mk_full;
	logic [KEY_W-1:0]  mk;
	logic              in_range;

	always_comb begin
		lo       = v6 ? V6_MASK_LO : V4_MASK_LO;
		hi       = v6 ? V6_MASK_HI : V4_MASK_HI;
		in_range = (cand.mask >= lo) && (cand.mask <= hi);
		// only meaningful when in range, so the shift stays below the key width
		shamt    = MASK_W'(KEY_W) - cand.mask;
		mk_full  = {KEY_W{1'b1}} << shamt;
		mk       = v6 ? mk_full : (mk_full >> V4_KEY_W);
		hit      = in_range && (cand.key != '0) && (((addr ^ cand.key) & mk) == '0);
	end

endmodule

// ===== sv/ip_prefix_predecessor_table.sv =====
`timescale 1ns / 1ps
// sorted ipv4/ipv6 prefix table with predecessor lookup
// requests arrive on s_axis: tuser selects the request (insert, delete, find, clear)
// and the family, tdata carries key, mask length and value handle. one result per
// request leaves on m_axis: tuser holds status and hit, tdata the found handle and
// both entry counts.
// each table is a row of cells in ascending key order; every cell compares its key
// with the request key at once, and insert or delete shifts the row by one cell
// in the update step, each cell taking its neighbor's entry.
// m_axis_tvalid rises once the request has passed its steps: compare across the row,
// shift and select, match into the output register; the next request is taken only
// after the result is loaded into the output register, so requests never overlap.
// if m_axis stalls, the result waits in the output register and the block holds
// the following request in its final step until the register frees.
// reset empties both tables at once (fill counts go to zero); no clearing pass.
`include "ip_prefix_predecessor_table_macros.svh"
module ip_prefix_predecessor_table import ippt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [87:0] s_axis_tdata,  // key[63:0], mask_len[71:64], value_handle[87:72]
	input  logic [2:0]  s_axis_tuser,  // req_type[1:0], family[2]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // found_handle[15:0], count_v4[22:16], count_v6[29:23], zero
	output logic [3:0]  m_axis_tuser   // status[2:0], hit[3]
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_CMP  = 4'b0010,
		S_UPD  = 4'b0100,
		S_RES  = 4'b1000
	} state_t;

	state_t state_q;

	req_t                   req_q;
	logic                   v6_q;
	logic [KEY_W-1:0]       key_q;
	logic [MASK_W-1:0]      mask_q;
	logic [HANDLE_BITS-1:0] handle_q;

	logic [TOTAL_CELLS-1:0] le_q;
	logic [TOTAL_CELLS-1:0] eq_q;
	status_t                st_q;
	entry_t                 sel_q;
	logic                   empty_q;

	logic [FILL4_W-1:0] fill4_q;
	logic [FILL6_W-1:0] fill6_q;

	logic                    out_valid_q;
	status_t                 out_status_q;
	logic                    out_hit_q;
	logic [OUT_HANDLE_W-1:0] out_handle_q;
	logic [COUNT_W-1:0]      out_c4_q;
	logic [COUNT_W-1:0]      out_c6_q;

	entry_t      entries_w [TOTAL_CELLS];
	entry_t      left_w    [TOTAL_CELLS];
	entry_t      right_w   [TOTAL_CELLS];
	cell_flags_t flags_w   [TOTAL_CELLS];
	cell_op_t    op_w      [TOTAL_CELLS];
	logic [TOTAL_CELLS-1:0] valid_w;
	logic [TOTAL_CELLS-1:0] region_w;
	logic [TOTAL_CELLS-1:0] le_left_w;
	logic [TOTAL_CELLS-1:0] le_right_w;
	logic [TOTAL_CELLS-1:0] sel_vec;

	entry_t  new_entry;
	entry_t  sel_w;
	status_t st_w;
	logic    eq_any;
	logic    full;
	logic    empty_w;
	logic    do_ins;
	logic    do_del;
	logic    match_hit;
	logic    accept;
	logic    load_out;

	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign load_out      = (state_q == S_RES) && (!out_valid_q || m_axis_tready);

	assign new_entry.key    = key_q;
	assign new_entry.mask   = mask_q;
	assign new_entry.handle = handle_q;

	// row of cells: ipv4 cells first, then ipv6 cells; no shift crosses the boundary
	for (genvar i = 0; i < TOTAL_CELLS; i++) begin : g_cell
		localparam bit IS_V6 = (i >= V4_ENTRIES);
		localparam int J     = IS_V6 ? i - V4_ENTRIES : i;
		localparam int N     = IS_V6 ? V6_ENTRIES : V4_ENTRIES;
		localparam bit FIRST = (J == 0);
		localparam bit LAST  = (J == N - 1);

		if (IS_V6) begin : g_v6
			assign valid_w[i] = (fill6_q > FILL6_W'(J));
		end else begin : g_v4
			assign valid_w[i] = (fill4_q > FILL4_W'(J));
		end

		if (FIRST) begin : g_first
			assign left_w[i]    = entries_w[i];
			assign le_left_w[i] = 1'b1;
		end else begin : g_mid_l
			assign left_w[i]    = entries_w[i-1];
			assign le_left_w[i] = le_q[i-1];
		end

		if (LAST) begin : g_last
			assign right_w[i]    = entries_w[i];
			assign le_right_w[i] = 1'b0;
		end else begin : g_mid_r
			assign right_w[i]    = entries_w[i+1];
			assign le_right_w[i] = le_q[i+1];
		end

		assign region_w[i] = (v6_q == IS_V6);
		// predecessor is the last cell at or below the key, else the first cell
		assign sel_vec[i]  = region_w[i] &&
			((le_q[i] && !le_right_w[i]) || (FIRST && !le_q[i]));

		always_comb begin
			op_w[i] = OP_HOLD;
			if (state_q == S_UPD && region_w[i]) begin
				if (do_ins) begin
					if (!le_left_w[i]) begin
						op_w[i] = OP_LEFT;
					end else if (!le_q[i]) begin
						op_w[i] = OP_NEW;
					end
				end else if (do_del && !LAST && (!le_q[i] || eq_q[i])) begin
					op_w[i] = OP_RIGHT;
				end
			end
		end

		ippt_cell u_cell (
			.clk         (clk),
			.op          (op_w[i]),
			.new_entry   (new_entry),
			.left_entry  (left_w[i]),
			.right_entry (right_w[i]),
			.cmp_key     (key_q),
			.valid       (valid_w[i]),
			.entry       (entries_w[i]),
			.flags       (flags_w[i])
		);
	end

	always_comb begin
		sel_w = '0;
		for (int i = 0; i < TOTAL_CELLS; i++) begin
			sel_w = sel_w | (sel_vec[i] ? entries_w[i] : '0);
		end
	end

	assign eq_any  = |(eq_q & region_w);
	assign full    = v6_q ? (fill6_q >= FILL6_W'(V6_ENTRIES)) : (fill4_q >= FILL4_W'(V4_ENTRIES));
	assign empty_w = v6_q ? (fill6_q == '0) : (fill4_q == '0);

	always_comb begin
		st_w = ST_OK;
		unique case (req_q)
			REQ_INSERT: begin
				priority if (v6_q && mask_q > V6_MASK_HI) st_w = ST_MASK;
				else if (key_q == '0) st_w = ST_ZERO;
				else if (eq_any) st_w = ST_DUP;
				else if (full) st_w = ST_FULL;
				else st_w = ST_OK;
			end
			REQ_DELETE: begin
				priority if (key_q == '0) st_w = ST_ZERO;
				else if (!eq_any) st_w = ST_MISS;
				else st_w = ST_OK;
			end
			REQ_FIND:  st_w = ST_OK;
			REQ_CLEAR: st_w = ST_OK;
		endcase
	end

	assign do_ins = (req_q == REQ_INSERT) && (st_w == ST_OK);
	assign do_del = (req_q == REQ_DELETE) && (st_w == ST_OK);

	ippt_match u_match (
		.cand (sel_q),
		.addr (key_q),
		.v6   (v6_q),
		.hit  (match_hit)
	);

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill4_q     <= '0;
			fill6_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept) state_q <= S_CMP;
				S_CMP:  state_q <= S_UPD;
				S_UPD: begin
					state_q <= S_RES;
					if (req_q == REQ_CLEAR) begin
						fill4_q <= '0;
						fill6_q <= '0;
					end else if (do_ins) begin
						if (v6_q) fill6_q <= fill6_q + FILL6_W'(1);
						else fill4_q <= fill4_q + FILL4_W'(1);
					end else if (do_del) begin
						if (v6_q) fill6_q <= fill6_q - FILL6_W'(1);
						else fill4_q <= fill4_q - FILL4_W'(1);
					end
				end
				S_RES: if (load_out) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// request, flags and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			req_q    <= req_t'(s_axis_tuser[1:0]);
			v6_q     <= s_axis_tuser[2];
			key_q    <= s_axis_tuser[2] ? s_axis_tdata[63:0]
			                            : {{(KEY_W-V4_KEY_W){1'b0}}, s_axis_tdata[V4_KEY_W-1:0]};
			mask_q   <= s_axis_tdata[71:64];
			handle_q <= HANDLE_BITS'(s_axis_tdata[87:72]);
		end
		if (state_q == S_CMP) begin
			for (int i = 0; i < TOTAL_CELLS; i++) begin
				le_q[i] <= flags_w[i].le;
				eq_q[i] <= flags_w[i].eq;
			end
		end
		if (state_q == S_UPD) begin
			st_q    <= st_w;
			sel_q   <= sel_w;
			empty_q <= empty_w;
		end
		if (load_out) begin
			out_c4_q <= COUNT_W'(fill4_q);
			out_c6_q <= COUNT_W'(fill6_q);
			if (req_q == REQ_FIND) begin
				out_hit_q    <= !empty_q && match_hit;
				out_status_q <= (!empty_q && match_hit) ? ST_OK : ST_MISS;
				out_handle_q <= (!empty_q && match_hit) ? OUT_HANDLE_W'(sel_q.handle) : '0;
			end else begin
				out_hit_q    <= 1'b0;
				out_status_q <= st_q;
				out_handle_q <= '0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {2'b00, out_c6_q, out_c4_q, out_handle_q};
	assign m_axis_tuser  = {out_hit_q, out_status_q};

	`IPPT_ASSERT_NEXT(a_accept_cmp, accept, state_q == S_CMP, "accepted request did not start compare")
	`IPPT_ASSERT_IMP(a_sel_onehot, state_q == S_UPD, $onehot(sel_vec), "predecessor select not one-hot")
	`IPPT_ASSERT_NEXT(a_ins_v4, state_q == S_UPD && do_ins && !v6_q, fill4_q == $past(fill4_q) + FILL4_W'(1), "ipv4 fill did not grow on insert")
	`IPPT_ASSERT_IMP(a_hit_ok, out_valid_q && out_hit_q, out_status_q == ST_OK, "hit reported with non-ok status")

endmodule

// ===== sim/prefix_table_checker.sv =====
`timescale 1ns / 1ps
module prefix_table_checker import ippt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,   // key[63:0], mask_len[71:64], value_handle[87:72]
	input  logic [2:0]  s_tuser,   // req_type[1:0], family[2]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [31:0] m_tdata,   // found_handle[15:0], count_v4[22:16], count_v6[29:23]
	input  logic [3:0]  m_tuser,   // status[2:0], hit[3]
	output int          fail_count,
	output int          pending,
	output int          checked,
	output int          hits,
	output int          fulls
);

	localparam int DEPTH = (V4_ENTRIES > V6_ENTRIES) ? V4_ENTRIES : V6_ENTRIES;

	typedef struct {
		status_t                 status;
		logic                    hit;
		logic [OUT_HANDLE_W-1:0] handle;
		logic [COUNT_W-1:0]      v4_count;
		logic [COUNT_W-1:0]      v6_count;
	} lookup_result_t;

	// index 0 is the ipv4 table, index 1 the ipv6 table
	logic [KEY_W-1:0]       tab_key    [2][DEPTH];
	logic [MASK_W-1:0]      tab_mask   [2][DEPTH];
	logic [HANDLE_BITS-1:0] tab_handle [2][DEPTH];
	int                     tab_fill   [2];

	lookup_result_t expected_results[$];

	task automatic note_failure(input string msg);
		$display("[%0t] %s", $time, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
		if (got !== want)
			note_failure($sformatf("result %0d: %s is %0h, expected %0h", checked, name, got, want));
	endtask

	function automatic int entries_at_or_below(input int f, input logic [63:0] k);
		int i;
		i = 0;
		while (i < tab_fill[f] && tab_key[f][i] <= k)
			i++;
		return i;
	endfunction

	task automatic predict_request(input req_t op, input logic fam, input logic [63:0] raw_key,
			input logic [7:0] mlen, input logic [15:0] hdl, output lookup_result_t res);
		int f, cap, n, pos, idx, nm, lo, width;
		logic [63:0] k, mk;
		f = fam;
		k = fam ? raw_key : {32'd0, raw_key[31:0]};
		cap = fam ? V6_ENTRIES : V4_ENTRIES;
		n = tab_fill[f];
		pos = entries_at_or_below(f, k);
		res.status = ST_OK;
		res.hit = 1'b0;
		res.handle = '0;
		case (op)
			REQ_INSERT: begin
				// ipv6 checks the mask length before the zero key
				if (fam && mlen > V6_MASK_HI)
					res.status = ST_MASK;
				else if (k == 0)
					res.status = ST_ZERO;
				else if (pos > 0 && tab_key[f][pos - 1] == k)
					res.status = ST_DUP;
				else if (n >= cap)
					res.status = ST_FULL;
				else begin
					for (int i = n; i > pos; i--) begin
						tab_key[f][i] = tab_key[f][i - 1];
						tab_mask[f][i] = tab_mask[f][i - 1];
						tab_handle[f][i] = tab_handle[f][i - 1];
					end
					tab_key[f][pos] = k;
					tab_mask[f][pos] = mlen;
					tab_handle[f][pos] = hdl[HANDLE_BITS-1:0];
					tab_fill[f] = n + 1;
				end
			end
			REQ_DELETE: begin
				if (k == 0)
					res.status = ST_ZERO;
				else if (pos == 0 || tab_key[f][pos - 1] != k)
					res.status = ST_MISS;
				else begin
					for (int i = pos - 1; i + 1 < n; i++) begin
						tab_key[f][i] = tab_key[f][i + 1];
						tab_mask[f][i] = tab_mask[f][i + 1];
						tab_handle[f][i] = tab_handle[f][i + 1];
					end
					tab_fill[f] = n - 1;
				end
			end
			REQ_FIND: begin
				res.status = ST_MISS;
				if (n > 0) begin
					// predecessor, or the first entry when every key is above the address
					idx = (pos > 0) ? pos - 1 : 0;
					nm = tab_mask[f][idx];
					lo = fam ? V6_MASK_LO : V4_MASK_LO;
					width = fam ? 64 : 32;
					if (tab_key[f][idx] != 0 && nm >= lo && nm <= width) begin
						mk = {64{1'b1}} << (64 - nm);
						mk = mk >> (64 - width);
						if ((k & mk) == (tab_key[f][idx] & mk)) begin
							res.status = ST_OK;
							res.hit = 1'b1;
							res.handle = OUT_HANDLE_W'(tab_handle[f][idx]);
						end
					end
				end
			end
			default: begin
				tab_fill[0] = 0;
				tab_fill[1] = 0;
			end
		endcase
		res.v4_count = COUNT_W'(tab_fill[0]);
		res.v6_count = COUNT_W'(tab_fill[1]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		lookup_result_t want;
		if (!arst_n) begin
			tab_fill[0] = 0;
			tab_fill[1] = 0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
			checked = 0;
			hits = 0;
			fulls = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				predict_request(req_t'(s_tuser[1:0]), s_tuser[2], s_tdata[63:0], s_tdata[71:64],
					s_tdata[87:72], want);
				if (want.hit)
					hits++;
				if (want.status == ST_FULL)
					fulls++;
				expected_results.insert(expected_results.size(), want);
			end
			if (m_tvalid && m_tready) begin
				if (expected_results.size() == 0) begin
					note_failure("result transfer with no request outstanding");
				end else begin
					want = expected_results.pop_front();
					check_field("status", 16'(m_tuser[2:0]), 16'(want.status));
					check_field("hit", 16'(m_tuser[3]), 16'(want.hit));
					check_field("found_handle", m_tdata[15:0], want.handle);
					check_field("count_v4", 16'(m_tdata[22:16]), 16'(want.v4_count));
					check_field("count_v6", 16'(m_tdata[29:23]), 16'(want.v6_count));
					checked++;
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

// ===== sim/tb_ip_prefix_predecessor_table.sv =====
`timescale 1ns / 1ps
module tb_ip_prefix_predecessor_table;
	import ippt_pkg::*;

	localparam int POOL_SIZE   = 20;
	localparam int PHASES      = 6;
	localparam int PHASE_ITEMS = 220;
	localparam int HOLD_CYCLES = 300;
	localparam int IDLE_LIMIT  = 4000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [87:0] s_axis_tdata;
	logic [2:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;
	logic [3:0]  m_axis_tuser;

	int fail_count, pending, checked, hits, fulls;

	// sender state
	int   burst_left;
	logic steady;
	logic hold_off;
	int   sent [4];

	logic [63:0] pool_key [2][POOL_SIZE];
	logic [7:0]  pool_len [2][POOL_SIZE];
	int          insert_pct [PHASES] = '{45, 70, 35, 60, 30, 55};
	int          delete_pct [PHASES] = '{15, 10, 25, 15, 30, 10};

	ip_prefix_predecessor_table dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	prefix_table_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_axis_tvalid),
		.s_tready   (s_axis_tready),
		.s_tdata    (s_axis_tdata),
		.s_tuser    (s_axis_tuser),
		.m_tvalid   (m_axis_tvalid),
		.m_tready   (m_axis_tready),
		.m_tdata    (m_axis_tdata),
		.m_tuser    (m_axis_tuser),
		.fail_count (fail_count),
		.pending    (pending),
		.checked    (checked),
		.hits       (hits),
		.fulls      (fulls)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [63:0] low_ones(input int n);
		return (n >= 64) ? {64{1'b1}} : ((64'd1 << n) - 64'd1);
	endfunction

	// called just after a falling edge; returns just after the falling edge that follows the transfer
	task automatic send_request(input req_t op, input logic fam, input logic [63:0] key,
			input logic [7:0] mlen, input logic [15:0] hdl);
		int gap;
		if (burst_left == 0) begin
			gap = steady ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
			burst_left = $urandom_range(1, 24);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {hdl, mlen, key};
		s_axis_tuser  <= {fam, op};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		sent[op]++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		burst_left = 0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	task automatic refresh_pools();
		int len;
		logic [63:0] k, lo_bits;
		for (int f = 0; f < 2; f++) begin
			for (int i = 0; i < POOL_SIZE; i++) begin
				len = f ? $urandom_range(16, 64) : $urandom_range(8, 32);
				k = {$urandom, $urandom};
				if (f) begin
					k = k & ~low_ones(64 - len);
				end else begin
					// upper half stays random, the block ignores it for ipv4
					lo_bits = low_ones(32 - len);
					k[31:0] = k[31:0] & ~lo_bits[31:0];
				end
				pool_key[f][i] = k;
				pool_len[f][i] = 8'(len);
			end
		end
	endtask

	task automatic random_request(input int ins_pct, input int del_pct);
		int r, f, i, pick;
		req_t op;
		logic fam;
		logic [63:0] key;
		logic [7:0] mlen;
		r = $urandom_range(0, 99);
		op = (r < ins_pct) ? REQ_INSERT :
			(r < ins_pct + del_pct) ? REQ_DELETE :
			(r < 99) ? REQ_FIND : REQ_CLEAR;
		fam = 1'($urandom_range(0, 1));
		f = fam;
		i = $urandom_range(0, POOL_SIZE - 1);
		pick = $urandom_range(0, 99);
		if (pick < 4) begin
			key = fam ? 64'd0 : {$urandom, 32'd0};
		end else if (pick < 12) begin
			key = {$urandom, $urandom};
		end else begin
			key = pool_key[f][i];
			// lookups land somewhere under the prefix, sometimes outside it
			if (op == REQ_FIND)
				key = key ^ ({$urandom, $urandom} & low_ones($urandom_range(0, fam ? 64 : 32)));
		end
		mlen = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : pool_len[f][i];
		send_request(op, fam, key, mlen, 16'($urandom));
	endtask

	// overfill both tables, each followed by a duplicate at capacity, some lookups and a delete; then a clear
	task automatic fill_tables();
		int entries;
		logic [63:0] k, first_k;
		for (int f = 0; f < 2; f++) begin
			entries = f ? V6_ENTRIES : V4_ENTRIES;
			first_k = '0;
			for (int n = 0; n < entries + 3; n++) begin
				k = {$urandom, $urandom} | 64'd1;
				if (n == 0)
					first_k = k;
				send_request(REQ_INSERT, 1'(f), k,
					8'(f ? $urandom_range(16, 64) : $urandom_range(8, 32)), 16'($urandom));
			end
			send_request(REQ_INSERT, 1'(f), first_k, 8'd20, 16'($urandom));
			for (int n = 0; n < 10; n++)
				send_request(REQ_FIND, 1'(f), {$urandom, $urandom}, 8'd0, 16'd0);
			send_request(REQ_DELETE, 1'(f), first_k, 8'd0, 16'd0);
		end
		send_request(REQ_CLEAR, 1'b0, {$urandom, $urandom}, 8'($urandom), 16'($urandom));
	endtask

	// receiver: changes its stall pattern every so often, long hold-off on request
	initial begin : receiver
		int mode, left, tick;
		logic held;
		m_axis_tready = 1'b0;
		left = 0;
		tick = 0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_off && !held) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			if (left == 0) begin
				mode = $urandom_range(0, 3);
				left = $urandom_range(20, 200);
			end
			left--;
			tick++;
			case (mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ((tick % 7) < 4);
				default: m_axis_tready <= 1'($urandom_range(0, 1));
			endcase
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		@(posedge arst_n);
		while (idle < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle = 0;
			else
				idle++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		hold_off = 1'b0;
		steady = 1'b0;
		burst_left = 0;
		sent = '{0, 0, 0, 0};
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// empty tables, rejects, boundary masks and handles, every request kind
		send_request(REQ_FIND, 1'b0, 64'h0000_0000_1234_5678, 8'd0, 16'd0);
		send_request(REQ_FIND, 1'b1, 64'h2001_0DB8_0000_0001, 8'd0, 16'd0);
		send_request(REQ_INSERT, 1'b0, 64'hFFFF_FFFF_0000_0000, 8'd24, 16'h1111);
		send_request(REQ_INSERT, 1'b1, 64'h0, 8'd65, 16'h2222);
		send_request(REQ_INSERT, 1'b1, 64'h0, 8'd64, 16'h3333);
		send_request(REQ_INSERT, 1'b0, 64'hDEAD_BEEF_0A00_0000, 8'd8, 16'hFFFF);
		send_request(REQ_INSERT, 1'b0, 64'h0000_0000_0A00_0000, 8'd24, 16'h0001);
		send_request(REQ_INSERT, 1'b0, 64'h0000_0000_FFFF_FFFF, 8'd255, 16'h0000);
		send_request(REQ_INSERT, 1'b0, 64'h0000_0000_C0A8_0000, 8'd16, 16'h5555);
		send_request(REQ_INSERT, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'd64, 16'h1234);
		send_request(REQ_INSERT, 1'b1, 64'h2001_0DB8_0000_0000, 8'd32, 16'hABCD);
		send_request(REQ_INSERT, 1'b1, 64'h3000_0000_0000_0000, 8'd8, 16'h00FF);
		send_request(REQ_FIND, 1'b0, 64'h0000_0000_0A0B_0C0D, 8'd0, 16'd0);
		send_request(REQ_FIND, 1'b0, 64'h0000_0000_09FF_FFFF, 8'd0, 16'd0);
		send_request(REQ_FIND, 1'b0, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'd0);
		send_request(REQ_FIND, 1'b0, 64'h0000_0000_C0A8_FFFF, 8'd0, 16'd0);
		send_request(REQ_FIND, 1'b1, 64'h2001_0DB8_FFFF_0000, 8'd0, 16'd0);
		send_request(REQ_FIND, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 8'd0, 16'd0);
		send_request(REQ_FIND, 1'b1, 64'h3000_0000_0000_0001, 8'd0, 16'd0);
		send_request(REQ_DELETE, 1'b0, 64'hFFFF_FFFF_0000_0000, 8'd0, 16'd0);
		send_request(REQ_DELETE, 1'b0, 64'h0000_0000_0B00_0000, 8'd0, 16'd0);
		send_request(REQ_DELETE, 1'b0, 64'h0000_0000_0A00_0000, 8'd0, 16'd0);
		send_request(REQ_DELETE, 1'b1, 64'h3000_0000_0000_0000, 8'd0, 16'd0);
		send_request(REQ_CLEAR, 1'b1, 64'h0, 8'd0, 16'd0);
		send_request(REQ_FIND, 1'b0, 64'h0000_0000_C0A8_0001, 8'd0, 16'd0);
		wait_drained();

		fill_tables();

		for (int ph = 0; ph < PHASES; ph++) begin
			steady = (ph == 3);
			refresh_pools();
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (ph == 1 && n == 30)
					hold_off = 1'b1;
				random_request(insert_pct[ph], delete_pct[ph]);
			end
			if (ph == 2 || ph == 4)
				wait_drained();
		end

		wait_drained();
		repeat (8) @(negedge clk);
		$display("sent %0d inserts, %0d deletes, %0d finds and %0d clears; %0d results checked",
			sent[REQ_INSERT], sent[REQ_DELETE], sent[REQ_FIND], sent[REQ_CLEAR], checked);
		$display("%0d lookups matched a prefix, %0d inserts turned away by a full table",
			hits, fulls);
		if (fail_count == 0 && pending == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+sv
sv/ippt_pkg.sv
sv/ippt_cell.sv
sv/ippt_match.sv
sv/ip_prefix_predecessor_table.sv
sim/prefix_table_checker.sv
sim/tb_ip_prefix_predecessor_table.sv
